### rtl/core/tksi_pkg.sv
// Shared types and constants for the top-k score insertion block.
// No dependencies; compile first.
package tksi_pkg;

    localparam int TKSI_MAX_DEPTH = 32;
    localparam int ID_W           = 20;
    localparam int SCORE_W        = 32;
    localparam int RANK_W         = 6;
    localparam int DEPTH_W        = 7;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd32;

    // item kind codes
    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_DUMP  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } tksi_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
    } tksi_stat_t;

endpackage

### rtl/core/tksi_if.sv
// Handshake channel interfaces: input items, ranked results, configuration.
// Depends on tksi_pkg.
interface tksi_item_if
    import tksi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ID_W-1:0]    candidate_id;
    logic [SCORE_W-1:0] score;

    modport source (output valid, kind, candidate_id, score, input ready);
    modport sink   (input valid, kind, candidate_id, score, output ready);
endinterface

interface tksi_result_if
    import tksi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RANK_W-1:0]  rank;
    logic [ID_W-1:0]    ranked_id;
    logic [SCORE_W-1:0] ranked_score;
    logic               last;

    modport source (output valid, rank, ranked_id, ranked_score, last, input ready);
    modport sink   (input valid, rank, ranked_id, ranked_score, last, output ready);
endinterface

interface tksi_cfg_if
    import tksi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_in_use;

    modport source (output valid, depth_in_use, input ready);
    modport sink   (input valid, depth_in_use, output ready);
endinterface

### rtl/core/tksi_ctrl.sv
// Controller: idle/dump state machine and rank counter, issues list commands.
// Depends on tksi_pkg.
module tksi_ctrl
    import tksi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_fire,
    input  logic              item_kind,
    input  logic              out_ready,
    input  tksi_stat_t        stat,
    output logic              item_ready,
    output logic              out_valid,
    output logic [RANK_W-1:0] out_rank,
    output logic              out_last,
    output tksi_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t            state_reg, state_next;
    logic [RANK_W-1:0] cnt_reg, cnt_next;
    logic              valid_reg, valid_next;
    logic              out_fire;

    assign out_fire   = valid_reg && out_ready;
    assign out_last   = (({1'b0, cnt_reg}) + DEPTH_W'(1)) == stat.depth;
    assign out_valid  = valid_reg;
    assign out_rank   = cnt_reg;
    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && item_kind == KIND_OFFER)
                begin
                    cmd.insert = 1'b1;
                end
                else if (item_fire)
                begin
                    state_next = ST_DUMP;
                    cnt_next   = '0;
                    valid_next = 1'b1;
                end
            end
            ST_DUMP:
            begin
                if (out_fire)
                begin
                    cmd.shift = 1'b1;
                    if (out_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                        valid_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + RANK_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    a_no_item_while_dumping: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !item_ready)
        else $error("item ready while results pending");

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_last) |=> (state_reg == ST_IDLE && !valid_reg))
        else $error("dump did not end after last beat");

    a_rank_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !out_last) |=> (cnt_reg == $past(cnt_reg) + RANK_W'(1)))
        else $error("rank did not advance");

endmodule

### rtl/core/tksi_datapath.sv
// Datapath: ranked score/id registers, parallel insertion, dump shift, depth register.
// Depends on tksi_pkg.
module tksi_datapath
    import tksi_pkg::*;
#(
    parameter int MAX_DEPTH = TKSI_MAX_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tksi_cmd_t          cmd,
    input  logic [ID_W-1:0]    cand_id,
    input  logic [SCORE_W-1:0] cand_score,
    input  logic               cfg_we,
    input  logic [DEPTH_W-1:0] cfg_depth,
    output tksi_stat_t         stat,
    output logic [ID_W-1:0]    head_id,
    output logic [SCORE_W-1:0] head_score
);

    localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_DEPTH);

    logic [SCORE_W-1:0] score_reg [MAX_DEPTH];
    logic [SCORE_W-1:0] score_next[MAX_DEPTH];
    logic [ID_W-1:0]    id_reg    [MAX_DEPTH];
    logic [ID_W-1:0]    id_next   [MAX_DEPTH];
    logic [SCORE_W-1:0] score_above[MAX_DEPTH];
    logic [ID_W-1:0]    id_above   [MAX_DEPTH];
    logic [SCORE_W-1:0] score_below[MAX_DEPTH];
    logic [ID_W-1:0]    id_below   [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] take;
    logic [MAX_DEPTH-1:0] take_above;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_act;

    // clamp to 1..MAX_DEPTH
    always_comb
    begin
        if (depth_reg == '0)
            depth_act = DEPTH_W'(1);
        else if (depth_reg > MAX_D)
            depth_act = MAX_D;
        else
            depth_act = depth_reg;
    end

    assign stat.depth = depth_act;
    assign head_score = score_reg[0];
    assign head_id    = id_reg[0];

    // neighbor taps
    always_comb
    begin
        score_above[0]           = '0;
        id_above[0]              = '0;
        score_below[MAX_DEPTH-1] = '0;
        id_below[MAX_DEPTH-1]    = '0;
        for (int p = 1; p < MAX_DEPTH; p++)
        begin
            score_above[p] = score_reg[p-1];
            id_above[p]    = id_reg[p-1];
        end
        for (int p = 0; p < MAX_DEPTH - 1; p++)
        begin
            score_below[p] = score_reg[p+1];
            id_below[p]    = id_reg[p+1];
        end
    end

    // list is descending, so the places that lose to the offer form a suffix
    always_comb
    begin
        for (int p = 0; p < MAX_DEPTH; p++)
        begin
            take[p] = (DEPTH_W'(p) < depth_act) && (score_reg[p] < cand_score);
        end
        take_above = take << 1;
    end

    always_comb
    begin
        for (int p = 0; p < MAX_DEPTH; p++)
        begin
            score_next[p] = score_reg[p];
            id_next[p]    = id_reg[p];
            if (cmd.clear)
            begin
                score_next[p] = '0;
                id_next[p]    = '0;
            end
            else if (cmd.shift)
            begin
                score_next[p] = score_below[p];
                id_next[p]    = id_below[p];
            end
            else if (cmd.insert && take[p])
            begin
                if (take_above[p])
                begin
                    score_next[p] = score_above[p];
                    id_next[p]    = id_above[p];
                end
                else
                begin
                    score_next[p] = cand_score;
                    id_next[p]    = cand_id;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < MAX_DEPTH; p++)
            begin
                score_reg[p] <= '0;
                id_reg[p]    <= '0;
            end
            depth_reg <= DEPTH_RESET;
        end
        else
        begin
            for (int p = 0; p < MAX_DEPTH; p++)
            begin
                score_reg[p] <= score_next[p];
                id_reg[p]    <= id_next[p];
            end
            if (cfg_we)
                depth_reg <= cfg_depth;
        end
    end

    a_clear_empties_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (score_reg[0] == '0 && id_reg[0] == '0))
        else $error("head not cleared");

    a_best_offer_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && cand_score > score_reg[0])
        |=> (score_reg[0] == $past(cand_score) && id_reg[0] == $past(cand_id)))
        else $error("best offer not placed at head");

    a_depth_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_act != '0) && (depth_act <= MAX_D))
        else $error("active depth out of range");

endmodule

### rtl/core/top_k_score_insert.sv
// Top level of the top-k score insertion list: channel wiring of controller and datapath.
// Depends on tksi_pkg, tksi_if, tksi_ctrl, tksi_datapath.
//
//  channel   dir  beat moves                                     accepted when
//  items     in   kind, candidate_id, score                      valid && ready
//  results   out  rank, ranked_id, ranked_score, last            valid && ready
//  cfg       in   depth_in_use (7 bits)                          valid && ready
//
// Cycles: an offer beat is inserted in the cycle it is accepted, so offers stream
//   at one per cycle while no dump is under way; the insert is a parallel
//   compare of every list entry. An accepted dump beat is followed by d result
//   beats (d is depth_in_use clamped to 1..MAX_DEPTH), one per cycle when results
//   is ready; the list shifts up one entry per result beat.
// Items ready is low from the cycle after a dump beat until its last result
//   beat is taken; a stalled result holds the list and the rank.
// Reset: list all zero scores and ids, depth_in_use 32; cfg is always ready.
module top_k_score_insert
    import tksi_pkg::*;
#(
    parameter int MAX_DEPTH = TKSI_MAX_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    tksi_item_if.sink     items,
    tksi_result_if.source results,
    tksi_cfg_if.sink      cfg
);

    tksi_cmd_t  cmd;
    tksi_stat_t stat;
    logic       item_ready;
    logic       item_fire;

    // items stall for the whole of a dump
    assign items.ready = item_ready;
    assign item_fire   = items.valid && item_ready;

    // depth register takes a write on any beat
    assign cfg.ready = 1'b1;

    tksi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_fire  (item_fire),
        .item_kind  (items.kind),
        .out_ready  (results.ready),
        .stat       (stat),
        .item_ready (item_ready),
        .out_valid  (results.valid),
        .out_rank   (results.rank),
        .out_last   (results.last),
        .cmd        (cmd)
    );

    // result payload is the head of the list, which shifts up on each beat
    tksi_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cand_id    (items.candidate_id),
        .cand_score (items.score),
        .cfg_we     (cfg.valid),
        .cfg_depth  (cfg.depth_in_use),
        .stat       (stat),
        .head_id    (results.ranked_id),
        .head_score (results.ranked_score)
    );

endmodule
